FILE: rtl/core/lgc_pkg.sv
// shared types, sizes and the fraction table of the 3d lut color grader
package lgc_pkg;

    localparam int MAX_GRID    = 33;
    localparam int CFG_W       = 6;
    localparam int GRID_W      = $clog2(MAX_GRID + 1);
    localparam int COORD_W     = $clog2(MAX_GRID);
    localparam int RG_W        = $clog2(MAX_GRID * MAX_GRID);
    localparam int STORE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 8 + COORD_W;
    localparam int FRAC_W      = 12;
    localparam int ENTRY_W     = 48;

    typedef struct packed {
        logic               mode;
        logic [15:0]        lut_address;
        logic signed [15:0] entry_red;
        logic signed [15:0] entry_green;
        logic signed [15:0] entry_blue;
        logic [7:0]         pix_red;
        logic [7:0]         pix_green;
        logic [7:0]         pix_blue;
        logic [7:0]         pix_alpha;
    } lgc_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } lgc_out_t;

    typedef logic [FRAC_W-1:0] frac_table_t [256];

    // round(rem * 4096 / 255), half up
    function automatic frac_table_t build_frac_table();
        frac_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = FRAC_W'((i * 4096 + 127) / 255);
        end
        return t;
    endfunction

    localparam frac_table_t FRAC_TABLE = build_frac_table();

endpackage

FILE: rtl/core/lgc_ram.sv
// generic ram: one write port, two registered read ports
module lgc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: rtl/core/lgc_axis.sv
// splits one color byte into grid cell, upper neighbor and q0.12 fraction
module lgc_axis import lgc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [7:0]         pix,
    input  logic [COORD_W-1:0] last,
    output logic [COORD_W-1:0] lo_reg,
    output logic [COORD_W-1:0] hi_reg,
    output logic [FRAC_W-1:0]  frac_reg
);

    logic [POS_W-1:0]   pos_reg;
    logic [COORD_W-1:0] last_reg;
    logic [POS_W:0]     q_sum;
    logic [COORD_W:0]   quot;
    logic [POS_W-1:0]   rem_full;
    logic [COORD_W-1:0] lo_next;
    logic [COORD_W-1:0] hi_next;

    always_comb begin
        // pos / 255 as (pos + 1 + pos/256) / 256
        q_sum    = (POS_W+1)'(pos_reg) + (POS_W+1)'(1) + (POS_W+1)'(pos_reg >> 8);
        quot     = q_sum[POS_W:8];
        rem_full = pos_reg - POS_W'((POS_W'(quot) << 8) - POS_W'(quot));
        lo_next  = quot[COORD_W-1:0];
        hi_next  = (lo_next == last_reg) ? last_reg : lo_next + COORD_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg  <= POS_W'(pix) * POS_W'(last);
            last_reg <= last;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            frac_reg <= FRAC_TABLE[rem_full[7:0]];
        end
    end

endmodule

FILE: rtl/core/lgc_blend.sv
// one lerp lane a + round((b - a) * frac / 4096), two stages
module lgc_blend import lgc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    input  logic [FRAC_W-1:0]  frac,
    output logic signed [15:0] y_reg
);

    logic signed [16:0] diff;
    logic signed [30:0] prod_reg;
    logic signed [15:0] a_reg;
    logic signed [30:0] rounded;

    always_comb begin
        diff    = 17'(b) - 17'(a);
        rounded = (prod_reg + 31'sd2048) >>> 12;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 31'(diff) * $signed({19'b0, frac});
            a_reg    <= a;
            y_reg    <= a_reg + rounded[15:0];
        end
    end

endmodule

FILE: rtl/core/lut3d_trilinear_color_grade.sv
// top level of the trilinear 3d lut color grader
//
//  channel   ports                               role
//  s_        s_valid s_ready s_data (lgc_in_t)   table write or pixel request
//  m_        m_valid m_ready m_data (lgc_out_t)  graded pixel, one per pixel
//  cfg_      cfg_wr_en cfg_wr_data               grid points per axis
//
//  one request per cycle unless the output stalls; a taken pixel passes through
//  two axis stages, two address multiply stages, ram read, three lerp pairs and
//  the byte stage; a table write lands at the ram read stage and gives no output
//  the whole pipeline holds while m_valid is high and m_ready is low
//  reset clears valid bits and sets the grid to 33 points; table is unknown
module lut3d_trilinear_color_grade import lgc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lgc_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lgc_out_t         m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int NS = 12;

    logic                en;
    logic [GRID_W-1:0]   n_reg, n_next;
    logic [COORD_W-1:0]  last;
    logic [NS:1]         vld_reg, vld_next;

    logic                mode_reg  [1:4];
    logic [15:0]         waddr_reg [1:4];
    logic [ENTRY_W-1:0]  wdata_reg [1:4];
    logic [7:0]          alpha_reg [1:11];

    logic [COORD_W-1:0]  r_lo, r_hi, g_lo, g_hi, b_lo, b_hi;
    logic [FRAC_W-1:0]   fr, fg, fb;
    logic [FRAC_W-1:0]   fb_reg [3:5];
    logic [FRAC_W-1:0]   fg_reg [3:7];
    logic [FRAC_W-1:0]   fr_reg [3:9];

    logic [RG_W-1:0]     rg_reg [2][2];
    logic [COORD_W-1:0]  b0_reg, b1_reg;
    logic [ADDR_W-1:0]   addr_reg [2][2][2];
    logic [ENTRY_W-1:0]  rd_data [2][2][2];
    logic                wr_en;

    logic signed [15:0]  yb [2][2][3];
    logic signed [15:0]  yg [2][3];
    logic signed [15:0]  yr [3];
    logic [7:0]          byte_next [3];
    lgc_out_t            out_reg;

    assign en      = !vld_reg[NS] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NS];
    assign m_data  = out_reg;
    assign last    = COORD_W'(n_reg - GRID_W'(1));

    // grid size saturated to the legal range at write time
    always_comb begin
        int unsigned v;
        v      = 32'(cfg_wr_data);
        n_next = n_reg;
        if (cfg_wr_en) begin
            if (v < 2) begin
                n_next = GRID_W'(2);
            end else if (v > MAX_GRID) begin
                n_next = GRID_W'(MAX_GRID);
            end else begin
                n_next = GRID_W'(v);
            end
        end
    end

    always_comb begin
        vld_next    = vld_reg;
        vld_next[1] = s_valid;
        for (int i = 2; i <= NS; i++) begin
            vld_next[i] = vld_reg[i-1];
        end
        // table writes leave the pipe at the ram stage
        vld_next[5] = vld_reg[4] && mode_reg[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg   <= GRID_W'(MAX_GRID);
            vld_reg <= '0;
        end else begin
            n_reg <= n_next;
            if (en) begin
                vld_reg <= vld_next;
            end
        end
    end

    lgc_axis u_axis_r (.aclk, .en, .pix(s_data.pix_red), .last,
                       .lo_reg(r_lo), .hi_reg(r_hi), .frac_reg(fr));
    lgc_axis u_axis_g (.aclk, .en, .pix(s_data.pix_green), .last,
                       .lo_reg(g_lo), .hi_reg(g_hi), .frac_reg(fg));
    lgc_axis u_axis_b (.aclk, .en, .pix(s_data.pix_blue), .last,
                       .lo_reg(b_lo), .hi_reg(b_hi), .frac_reg(fb));

    // side payload carried along the pipe
    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg[1]  <= s_data.mode;
            waddr_reg[1] <= s_data.lut_address;
            wdata_reg[1] <= {s_data.entry_red, s_data.entry_green, s_data.entry_blue};
            alpha_reg[1] <= s_data.pix_alpha;
            for (int i = 2; i <= 4; i++) begin
                mode_reg[i]  <= mode_reg[i-1];
                waddr_reg[i] <= waddr_reg[i-1];
                wdata_reg[i] <= wdata_reg[i-1];
            end
            for (int i = 2; i <= 11; i++) begin
                alpha_reg[i] <= alpha_reg[i-1];
            end
            fb_reg[3] <= fb;
            fg_reg[3] <= fg;
            fr_reg[3] <= fr;
            for (int i = 4; i <= 5; i++) begin
                fb_reg[i] <= fb_reg[i-1];
            end
            for (int i = 4; i <= 7; i++) begin
                fg_reg[i] <= fg_reg[i-1];
            end
            for (int i = 4; i <= 9; i++) begin
                fr_reg[i] <= fr_reg[i-1];
            end
        end
    end

    // corner address (r*n + g)*n + b in two multiply stages
    always_ff @(posedge aclk) begin
        if (en) begin
            rg_reg[0][0] <= RG_W'(RG_W'(r_lo) * RG_W'(n_reg) + RG_W'(g_lo));
            rg_reg[0][1] <= RG_W'(RG_W'(r_lo) * RG_W'(n_reg) + RG_W'(g_hi));
            rg_reg[1][0] <= RG_W'(RG_W'(r_hi) * RG_W'(n_reg) + RG_W'(g_lo));
            rg_reg[1][1] <= RG_W'(RG_W'(r_hi) * RG_W'(n_reg) + RG_W'(g_hi));
            b0_reg       <= b_lo;
            b1_reg       <= b_hi;
            for (int ri = 0; ri < 2; ri++) begin
                for (int gi = 0; gi < 2; gi++) begin
                    addr_reg[ri][gi][0] <= ADDR_W'(ADDR_W'(rg_reg[ri][gi]) * ADDR_W'(n_reg)
                                           + ADDR_W'(b0_reg));
                    addr_reg[ri][gi][1] <= ADDR_W'(ADDR_W'(rg_reg[ri][gi]) * ADDR_W'(n_reg)
                                           + ADDR_W'(b1_reg));
                end
            end
        end
    end

    assign wr_en = en && vld_reg[4] && !mode_reg[4]
                   && (32'(waddr_reg[4]) < 32'(STORE_DEPTH));

    // four copies of the table, each serving one r/g pair of corners
    for (genvar ri = 0; ri < 2; ri++) begin : g_ram_r
        for (genvar gi = 0; gi < 2; gi++) begin : g_ram_g
            lgc_ram #(.DEPTH(STORE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
                .aclk,
                .en,
                .wr_en,
                .wr_addr   (ADDR_W'(waddr_reg[4])),
                .wr_data   (wdata_reg[4]),
                .rd_addr_a (addr_reg[ri][gi][0]),
                .rd_addr_b (addr_reg[ri][gi][1]),
                .rd_data_a (rd_data[ri][gi][0]),
                .rd_data_b (rd_data[ri][gi][1])
            );
        end
    end

    // lerp along blue, then green, then red
    for (genvar ri = 0; ri < 2; ri++) begin : g_lb_r
        for (genvar gi = 0; gi < 2; gi++) begin : g_lb_g
            for (genvar ch = 0; ch < 3; ch++) begin : g_lb_c
                lgc_blend u_blend (
                    .aclk, .en,
                    .a     ($signed(rd_data[ri][gi][0][47-16*ch -: 16])),
                    .b     ($signed(rd_data[ri][gi][1][47-16*ch -: 16])),
                    .frac  (fb_reg[5]),
                    .y_reg (yb[ri][gi][ch])
                );
            end
        end
    end

    for (genvar ri = 0; ri < 2; ri++) begin : g_lg_r
        for (genvar ch = 0; ch < 3; ch++) begin : g_lg_c
            lgc_blend u_blend (
                .aclk, .en,
                .a     (yb[ri][0][ch]),
                .b     (yb[ri][1][ch]),
                .frac  (fg_reg[7]),
                .y_reg (yg[ri][ch])
            );
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lr_c
        lgc_blend u_blend (
            .aclk, .en,
            .a     (yg[0][ch]),
            .b     (yg[1][ch]),
            .frac  (fr_reg[9]),
            .y_reg (yr[ch])
        );
    end

    // clamp to [0, 1.0] and round to a byte
    always_comb begin
        logic [12:0] v;
        logic [19:0] p;
        for (int ch = 0; ch < 3; ch++) begin
            if (yr[ch] < 16'sd0) begin
                v = '0;
            end else if (yr[ch] > 16'sd4096) begin
                v = 13'd4096;
            end else begin
                v = yr[ch][12:0];
            end
            p             = (20'(v) << 8) - 20'(v) + 20'd2048;
            byte_next[ch] = p[19:12];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.out_red   <= byte_next[0];
            out_reg.out_green <= byte_next[1];
            out_reg.out_blue  <= byte_next[2];
            out_reg.out_alpha <= alpha_reg[11];
        end
    end

endmodule

FILE: sim/tb_lut3d_trilinear_color_grade.sv
// testbench for the trilinear 3d lut color grader: table load, pixel grading, grid changes
`timescale 1ns / 100ps

import lgc_pkg::*;

class grade_scoreboard;
    logic signed [15:0] lut_r [STORE_DEPTH];
    logic signed [15:0] lut_g [STORE_DEPTH];
    logic signed [15:0] lut_b [STORE_DEPTH];
    int unsigned        grid = 33;
    lgc_out_t           expected_pixels [$];
    int                 mismatches = 0;
    int                 pixels_checked = 0;
    int                 writes_seen = 0;

    task report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    function int blend(int a, int b, int frac);
        longint t;
        t = longint'(b - a) * frac + 2048;
        return a + int'(t >>> 12);
    endfunction

    function void split_axis(int pix, int last, output int lo, output int hi, output int frac);
        int pos;
        pos = pix * last;
        lo = pos / 255;
        hi = (lo + 1 > last) ? last : lo + 1;
        frac = ((pos % 255) * 4096 + 127) / 255;
    endfunction

    function int entry(int n, int r, int g, int b, int ch);
        int idx;
        idx = (r * n + g) * n + b;
        case (ch)
            0: return lut_r[idx];
            1: return lut_g[idx];
            default: return lut_b[idx];
        endcase
    endfunction

    function int to_byte(int v);
        if (v < 0) v = 0;
        if (v > 4096) v = 4096;
        return (v * 255 + 2048) / 4096;
    endfunction

    function void note_request(lgc_in_t req);
        int n, last, r0, r1, g0, g1, b0, b1, fr, fg, fb, c0, c1;
        int res [3];
        lgc_out_t px;
        if (req.mode == 1'b0) begin
            writes_seen++;
            if (req.lut_address < STORE_DEPTH) begin
                lut_r[req.lut_address] = req.entry_red;
                lut_g[req.lut_address] = req.entry_green;
                lut_b[req.lut_address] = req.entry_blue;
            end
            return;
        end
        n = grid < 2 ? 2 : (grid > MAX_GRID ? MAX_GRID : grid);
        last = n - 1;
        split_axis(req.pix_red, last, r0, r1, fr);
        split_axis(req.pix_green, last, g0, g1, fg);
        split_axis(req.pix_blue, last, b0, b1, fb);
        for (int ch = 0; ch < 3; ch++) begin
            // blue first, then green, then red
            c0 = blend(blend(entry(n, r0, g0, b0, ch), entry(n, r0, g0, b1, ch), fb),
                       blend(entry(n, r0, g1, b0, ch), entry(n, r0, g1, b1, ch), fb), fg);
            c1 = blend(blend(entry(n, r1, g0, b0, ch), entry(n, r1, g0, b1, ch), fb),
                       blend(entry(n, r1, g1, b0, ch), entry(n, r1, g1, b1, ch), fb), fg);
            res[ch] = to_byte(blend(c0, c1, fr));
        end
        px.out_red   = 8'(res[0]);
        px.out_green = 8'(res[1]);
        px.out_blue  = 8'(res[2]);
        px.out_alpha = req.pix_alpha;
        expected_pixels.push_back(px);
    endfunction

    task check_pixel(lgc_out_t got);
        lgc_out_t want;
        if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", got, 0);
            return;
        end
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got.out_red !== want.out_red) report_mismatch("red", got.out_red, want.out_red);
        if (got.out_green !== want.out_green)
            report_mismatch("green", got.out_green, want.out_green);
        if (got.out_blue !== want.out_blue) report_mismatch("blue", got.out_blue, want.out_blue);
        if (got.out_alpha !== want.out_alpha)
            report_mismatch("alpha", got.out_alpha, want.out_alpha);
    endtask
endclass

module tb_lut3d_trilinear_color_grade;

    // entries 0 .. 1088: every read of grids up to 10 points, and of 33 points with red at zero
    localparam int LOAD_DEPTH = MAX_GRID * MAX_GRID;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    lgc_in_t          s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    lgc_out_t         m_data;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    grade_scoreboard sb = new();
    int  gap_pct = 0;
    int  stall_pct = 0;
    longint cycles = 0;
    logic [7:0] red_mask = 8'h00;

    lut3d_trilinear_color_grade dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_data);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == 3_000_000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_entry();
        if ($urandom_range(3) != 0)
            return 16'($signed($urandom_range(5200)) - 600);
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_request(lgc_in_t req);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic write_entry(int addr, logic signed [15:0] r, logic signed [15:0] g,
                               logic signed [15:0] b);
        lgc_in_t req;
        req = lgc_in_t'($urandom);
        req.mode = 1'b0;
        req.lut_address = 16'(addr);
        req.entry_red = r;
        req.entry_green = g;
        req.entry_blue = b;
        send_request(req);
    endtask

    task automatic grade_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        lgc_in_t req;
        req = '0;
        req.mode = 1'b1;
        req.lut_address = 16'($urandom);
        req.entry_red = 16'($urandom);
        req.entry_green = 16'($urandom);
        req.entry_blue = 16'($urandom);
        // full grid keeps red at zero so only loaded entries are read
        req.pix_red = r & red_mask;
        req.pix_green = g;
        req.pix_blue = b;
        req.pix_alpha = a;
        send_request(req);
    endtask

    // pending table writes give no output, so allow the pipeline depth after the last pixel
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_grid(int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.grid = value;
    endtask

    int grid_list [8] = '{33, 2, 0, 1, 63, 34, 10, 9};
    int gap_modes [4] = '{0, 61, 0, 33};
    int stall_modes [4] = '{0, 0, 61, 33};

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every entry a pixel can reach is loaded before any pixel
        for (int a = 0; a < LOAD_DEPTH; a++)
            write_entry(a, rand_entry(), rand_entry(), rand_entry());

        // extremes at both ends of the table, ignored out-of-range writes
        write_entry(0, 16'sh7fff, -16'sd32768, 16'sd4096);
        write_entry(STORE_DEPTH - 1, -16'sd32768, 16'sh7fff, -16'sd1);
        write_entry(STORE_DEPTH, 16'sd0, 16'sd0, 16'sd0);
        write_entry(16'hffff, 16'sd0, 16'sd0, 16'sd0);
        grade_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        grade_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        grade_pixel(8'd0, 8'd255, 8'd0, 8'h5a);
        grade_pixel(8'd255, 8'd0, 8'd255, 8'ha5);
        grade_pixel(8'd128, 8'd127, 8'd1, 8'd254);
        grade_pixel(8'd8, 8'd16, 8'd247, 8'd1);

        for (int p = 0; p < 8; p++) begin
            drain();
            set_grid(grid_list[p]);
            red_mask = (grid_list[p] >= MAX_GRID) ? 8'h00 : 8'hff;
            gap_pct = gap_modes[p % 4];
            stall_pct = stall_modes[p % 4];
            grade_pixel(8'd0, 8'd0, 8'd0, 8'd0);
            grade_pixel(8'd255, 8'd255, 8'd255, 8'd255);
            for (int i = 0; i < 120; i++) begin
                if (i == 60) drain();
                if ($urandom_range(99) < 15)
                    write_entry($urandom_range(19) == 0 ? int'($urandom_range(65535))
                                                        : int'($urandom_range(STORE_DEPTH - 1)),
                                rand_entry(), rand_entry(), rand_entry());
                else
                    grade_pixel(rand_byte(), rand_byte(), rand_byte(), 8'($urandom));
            end
        end

        drain();
        $display("covered %0d table writes and %0d graded pixels over 8 grid sizes,",
                 sb.writes_seen, sb.pixels_checked);
        $display("including saturated sizes and mixed sender gaps and receiver stalls");
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
